// ===== rtl/gss_pkg.sv =====
// Package for the gap span score sum block: field widths, opcodes, parameter
// defaults and the command and status structs between controller and datapath.
// No dependencies.
package gss_pkg;

   // Fixed request and response field widths
   localparam int OPCODE_W = 2;
   localparam int POS_W    = 5;
   localparam int ENTRY_W  = 32;
   localparam int COV_W    = 32;
   localparam int EST_W    = 32;

   // Parameter defaults
   localparam int NUM_POSITIONS_DEF = 32;
   localparam int SCORE_WIDTH_DEF   = 32;

   // Request opcodes
   localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic load;      // latch query fields, restart scan
      logic wr_entry;  // write one table entry from the request
      logic scan;      // advance the scan by one position
      logic clr_step;  // write one clear-sweep entry
      logic rsp_load;  // capture the final estimate
   } gss_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic scan_last;
      logic clr_last;
   } gss_status_type;

endpackage

// ===== rtl/gss_if.sv =====
// Request and response channel interfaces for the gap span score sum block.
// Depends on gss_pkg for field widths.
interface gss_req_if;
   import gss_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [OPCODE_W-1:0]        opcode;
   logic [POS_W-1:0]           span_start;
   logic [POS_W-1:0]           span_end;
   logic signed [ENTRY_W-1:0]  entry_score;
   logic [COV_W-1:0]           coverage;
   logic                       span_enable;

   modport source (
      output valid, opcode, span_start, span_end, entry_score, coverage, span_enable,
      input  ready
   );
   modport sink (
      input  valid, opcode, span_start, span_end, entry_score, coverage, span_enable,
      output ready
   );
endinterface

interface gss_rsp_if;
   import gss_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [EST_W-1:0]  estimate;
   logic                     saturated;

   modport source (
      output valid, estimate, saturated,
      input  ready
   );
   modport sink (
      input  valid, estimate, saturated,
      output ready
   );
endinterface

// ===== rtl/gap_span_score_sum.sv =====
// Top level of the gap span score sum block: controller plus datapath.
// Depends on gss_pkg, gss_if, gss_ctrl and gss_datapath.
//
// The block keeps a table of signed Q16.16 span scores addressed by start and
// end position and answers coverage queries with the saturating sum of the
// scores of every uncovered run. A write request completes in the cycle it is
// accepted. A query scans one position per cycle through a single table read
// port, then passes through its drain and finish states, where the response
// register is loaded as soon as any previous response is taken. A clear request,
// and the clearing pass that runs after reset, sweeps all table entries,
// 2^(2*ceil(log2(NUM_POSITIONS))) of them (1024 at 32 positions), one per cycle;
// req_ready stays low during the sweep. One request is in work at a time; the
// response register lets the next request be accepted while a response still
// waits.
module gap_span_score_sum #(
   parameter int NUM_POSITIONS = gss_pkg::NUM_POSITIONS_DEF,
   parameter int SCORE_WIDTH   = gss_pkg::SCORE_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   gss_req_if.sink      req_ch,
   gss_rsp_if.source    rsp_ch
);
   import gss_pkg::*;

   gss_cmd_type    cmd;
   gss_status_type status;

   // Sequence requests
   gss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ch.ready),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .status     (status),
      .cmd        (cmd)
   );

   // Table, scan and accumulate
   gss_datapath #(
      .NUM_POSITIONS (NUM_POSITIONS),
      .SCORE_WIDTH   (SCORE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_span_start  (req_ch.span_start),
      .req_span_end    (req_ch.span_end),
      .req_entry_score (req_ch.entry_score),
      .req_coverage    (req_ch.coverage),
      .req_span_enable (req_ch.span_enable),
      .rsp_estimate    (rsp_ch.estimate),
      .rsp_saturated   (rsp_ch.saturated)
   );

endmodule

// ===== rtl/gss_ctrl.sv =====
// Controller state machine for the gap span score sum block.
// Depends on gss_pkg for opcodes and the command/status structs.
module gss_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [gss_pkg::OPCODE_W-1:0]  req_opcode,
   output logic                          req_ready,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   input  gss_pkg::gss_status_type       status,
   output gss_pkg::gss_cmd_type          cmd
);
   import gss_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Decode commands and next state
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  OP_WRITE: cmd.wr_entry = 1'b1;
                  OP_QUERY: begin
                     cmd.load = 1'b1;
                     state_in = ST_SCAN;
                  end
                  OP_CLEAR: state_in = ST_CLEAR;
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the response until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/gss_datapath.sv =====
// Datapath of the gap span score sum block: span score memory, clear sweep,
// position scan, saturating accumulator and response register. Uses gss_pkg.
module gss_datapath #(
   parameter int NUM_POSITIONS = gss_pkg::NUM_POSITIONS_DEF,
   parameter int SCORE_WIDTH   = gss_pkg::SCORE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gss_pkg::gss_cmd_type                cmd,
   output gss_pkg::gss_status_type             status,
   input  logic [gss_pkg::POS_W-1:0]           req_span_start,
   input  logic [gss_pkg::POS_W-1:0]           req_span_end,
   input  logic signed [gss_pkg::ENTRY_W-1:0]  req_entry_score,
   input  logic [gss_pkg::COV_W-1:0]           req_coverage,
   input  logic                                req_span_enable,
   output logic signed [gss_pkg::EST_W-1:0]    rsp_estimate,
   output logic                                rsp_saturated
);
   import gss_pkg::*;

   localparam int PW    = $clog2(NUM_POSITIONS);
   localparam int CW    = $clog2(NUM_POSITIONS + 1);
   localparam int AW    = 2 * PW;
   localparam int Depth = 1 << AW;
   localparam int IW    = 7;
   localparam int SW    = SCORE_WIDTH;
   localparam int XW    = ((SW > ENTRY_W) ? SW : ENTRY_W) + 1;
   localparam int EW    = ((SW > EST_W) ? SW : EST_W) + 1;

   localparam logic signed [SW-1:0]    SMin     = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [SW-1:0]    SMax     = ~SMin;
   localparam logic signed [EST_W-1:0] EstMin   = {1'b1, {(EST_W-1){1'b0}}};
   localparam logic signed [EST_W-1:0] EstMax   = ~EstMin;
   localparam logic [IW-1:0]           NumPos   = IW'(NUM_POSITIONS);
   localparam logic [IW-1:0]           CovBits  = IW'(COV_W);

   logic signed [SW-1:0] mem [Depth];

   // Query state
   logic [COV_W-1:0]  cov_ff;
   logic [POS_W-1:0]  s_ff, e_ff;
   logic              en_ff;
   logic [CW-1:0]     pos_ff;
   logic              in_gap_ff;
   logic [PW-1:0]     gap_start_ff;
   logic              rd_pend_ff;
   logic signed [SW-1:0] rd_data_ff;
   logic signed [SW-1:0] acc_ff, acc_in;
   logic [AW-1:0]     clr_addr_ff;
   logic signed [EST_W-1:0] est_ff, est_in;
   logic              sat_ff, sat_in;

   logic [IW-1:0]     pos7, end7, s7, e7, ws7, we7;
   logic              covered;
   logic              issue;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic signed [SW-1:0] wr_data;
   logic signed [SW-1:0] clamp_val;
   logic signed [XW-1:0] ent_x;
   logic signed [SW:0]   sum;
   logic signed [EW-1:0] acc_x;
   logic [PW-1:0]     clr_row, clr_col;

   assign pos7 = IW'(pos_ff);
   assign end7 = pos7 - IW'(1);
   assign s7   = IW'(s_ff);
   assign e7   = IW'(e_ff);
   assign ws7  = IW'(req_span_start);
   assign we7  = IW'(req_span_end);

   // Coverage at the scan position; the position past the end counts as covered
   always_comb begin
      covered = 1'b0;
      if (pos7 >= NumPos) begin
         covered = 1'b1;
      end else begin
         if (pos7 < CovBits) begin
            covered = cov_ff[pos7[POS_W-1:0]];
         end
         if (en_ff && (s7 <= e7) && (pos7 >= s7) && (pos7 <= e7)) begin
            covered = 1'b1;
         end
      end
   end

   assign issue   = cmd.scan && covered && in_gap_ff;
   assign rd_addr = {gap_start_ff, end7[PW-1:0]};

   assign status.scan_last = (pos7 == NumPos);
   assign status.clr_last  = &clr_addr_ff;

   // Clamp an incoming score into the table range
   assign ent_x = XW'(req_entry_score);
   always_comb begin
      if (req_entry_score == EstMin) begin
         clamp_val = SMin;
      end else if (ent_x <= XW'(SMin)) begin
         clamp_val = SMin + SW'(1);
      end else if (ent_x > XW'(SMax)) begin
         clamp_val = SMax;
      end else begin
         clamp_val = ent_x[SW-1:0];
      end
   end

   // Select the memory write: clear sweep or single entry
   assign clr_row = clr_addr_ff[AW-1:PW];
   assign clr_col = clr_addr_ff[PW-1:0];
   always_comb begin
      if (cmd.clr_step) begin
         wr_en   = (clr_col >= clr_row);
         wr_addr = clr_addr_ff;
         wr_data = SMin;
      end else begin
         wr_en   = cmd.wr_entry && (ws7 < NumPos) && (we7 < NumPos);
         wr_addr = {ws7[PW-1:0], we7[PW-1:0]};
         wr_data = clamp_val;
      end
   end

   // Span score memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Saturating add of one gap score
   assign sum = (SW+1)'(acc_ff) + (SW+1)'(rd_data_ff);
   always_comb begin
      acc_in = acc_ff;
      if (cmd.load) begin
         acc_in = '0;
      end else if (rd_pend_ff) begin
         if ((acc_ff == SMin) || (rd_data_ff == SMin) || (sum <= (SW+1)'(SMin))) begin
            acc_in = SMin;
         end else if (sum > (SW+1)'(SMax)) begin
            acc_in = SMax;
         end else begin
            acc_in = sum[SW-1:0];
         end
      end
   end

   // Narrow the sum to the response range
   assign acc_x = EW'(acc_ff);
   always_comb begin
      sat_in = 1'b0;
      if ((acc_ff == SMin) || (acc_x <= EW'(EstMin))) begin
         est_in = EstMin;
         sat_in = 1'b1;
      end else if (acc_x > EW'(EstMax)) begin
         est_in = EstMax;
      end else begin
         est_in = acc_x[EST_W-1:0];
      end
   end

   // Control state: scan position, gap tracking, read pending, clear sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         in_gap_ff   <= 1'b0;
         rd_pend_ff  <= 1'b0;
         clr_addr_ff <= '0;
      end else begin
         rd_pend_ff <= issue;
         if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
         if (cmd.load) begin
            pos_ff    <= '0;
            in_gap_ff <= 1'b0;
         end else if (cmd.scan) begin
            pos_ff <= pos_ff + CW'(1);
            if (!covered && !in_gap_ff) begin
               in_gap_ff <= 1'b1;
            end else if (covered && in_gap_ff) begin
               in_gap_ff <= 1'b0;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (cmd.load) begin
         cov_ff <= req_coverage;
         s_ff   <= req_span_start;
         e_ff   <= req_span_end;
         en_ff  <= req_span_enable;
      end
      if (cmd.scan && !covered && !in_gap_ff) begin
         gap_start_ff <= pos7[PW-1:0];
      end
      if (cmd.rsp_load) begin
         est_ff <= est_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_estimate  = est_ff;
   assign rsp_saturated = sat_ff;

endmodule

// ===== rtl/gss_checker.sv =====
// Port-level checker for the gap span score sum block, bound to the top level.
// Depends on gss_pkg for opcodes and widths.
module gss_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [gss_pkg::OPCODE_W-1:0]        req_opcode,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [gss_pkg::EST_W-1:0]    rsp_estimate,
   input logic                                rsp_saturated
);
   import gss_pkg::*;

   // Clearing pass blocks requests right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during clearing pass");

   // A query or clear occupies the block for at least the next cycle
   a_busy_after_query: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && ((req_opcode == OP_QUERY) || (req_opcode == OP_CLEAR)))
      |=> !req_ready)
      else $error("ready high right after a query or clear");

   // Saturated flag exactly marks the minimum estimate code
   a_sat_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_saturated == (rsp_estimate == {1'b1, {(EST_W-1){1'b0}}})))
      else $error("saturated flag disagrees with estimate");

   // Stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_estimate) && $stable(rsp_saturated)))
      else $error("stalled response changed");

endmodule

bind gap_span_score_sum gss_checker u_gss_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_opcode    (req_ch.opcode),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_estimate  (rsp_ch.estimate),
   .rsp_saturated (rsp_ch.saturated)
);

// ===== test/testbench.sv =====
// Self-checking testbench for gap_span_score_sum: directed table, then random
// write/query/clear and undefined-opcode traffic checked against a span-score table predictor.
// Depends on gss_pkg, gss_if and the gap_span_score_sum RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import gss_pkg::*;

   localparam int NPOS           = NUM_POSITIONS_DEF;
   localparam int REQUEST_TARGET = 1950;
   localparam logic [OPCODE_W-1:0] OP_UNDEFINED = 2'd3;

   localparam logic signed [SCORE_WIDTH_DEF-1:0] MINUS_INF =
      {1'b1, {(SCORE_WIDTH_DEF-1){1'b0}}};
   localparam longint SCORE_MIN = longint'(MINUS_INF);
   localparam longint SCORE_MAX = -SCORE_MIN - 1;
   localparam longint EST_MIN   = -(longint'(1) <<< (EST_W-1));
   localparam longint EST_MAX   = -EST_MIN - 1;

   typedef struct packed {
      logic [OPCODE_W-1:0]       opcode;
      logic [POS_W-1:0]          span_start;
      logic [POS_W-1:0]          span_end;
      logic signed [ENTRY_W-1:0] entry_score;
      logic [COV_W-1:0]          coverage;
      logic                      span_enable;
   } span_request_type;

   typedef struct packed {
      logic signed [EST_W-1:0] estimate;
      logic                    saturated;
   } estimate_type;

   typedef struct packed {
      span_request_type request;
      logic             has_literal;
      estimate_type     literal;
   } table_row_type;

   logic clock = 1'b0;
   logic reset;

   gss_req_if req_bus ();
   gss_rsp_if rsp_bus ();

   gap_span_score_sum u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Predictor state and run bookkeeping
   logic signed [SCORE_WIDTH_DEF-1:0] span_table [NPOS][NPOS];
   estimate_type  expected_estimates [$];
   table_row_type directed_rows [$];

   bit bursts_on       = 1'b0;
   int hold_off_cycles = 0;
   int error_count     = 0;
   int requests_sent   = 0;
   int writes_sent     = 0;
   int queries_sent    = 0;
   int clears_sent     = 0;
   int ignored_sent    = 0;
   int estimates_seen  = 0;
   int saturated_seen  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard limit on run time
   initial begin
      #5ms;
      $display("timeout: %0d estimates still pending", expected_estimates.size());
      $display("testbench: done, errors");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      $display("mismatch at %0t: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Apply one request to the predicted table; return 1 with the estimate for a query
   function automatic bit model_request(input span_request_type r, output estimate_type result);
      logic [NPOS:0] covered;
      bit            in_gap;
      int            gap_lo, p, q;
      longint        total, part;
      result = '0;
      case (r.opcode)
         OP_WRITE: begin
            part = longint'(r.entry_score);
            if (part == EST_MIN) part = SCORE_MIN;
            else if (part <= SCORE_MIN) part = SCORE_MIN + 1;
            else if (part > SCORE_MAX) part = SCORE_MAX;
            if (r.span_start < NPOS && r.span_end < NPOS)
               span_table[r.span_start][r.span_end] = part[SCORE_WIDTH_DEF-1:0];
            return 1'b0;
         end
         OP_CLEAR: begin
            for (p = 0; p < NPOS; p++)
               for (q = p; q < NPOS; q++)
                  span_table[p][q] = MINUS_INF;
            return 1'b0;
         end
         OP_QUERY: begin
            // one extra covered position past the end closes a trailing gap
            covered = {1'b1, r.coverage[NPOS-1:0]};
            if (r.span_enable && r.span_start <= r.span_end)
               for (p = r.span_start; p <= r.span_end; p++)
                  covered[p] = 1'b1;
            total  = 0;
            in_gap = 1'b0;
            gap_lo = 0;
            for (p = 0; p <= NPOS; p++) begin
               if (!covered[p] && !in_gap) begin
                  in_gap = 1'b1;
                  gap_lo = p;
               end else if (covered[p] && in_gap) begin
                  in_gap = 1'b0;
                  part   = longint'(span_table[gap_lo][p-1]);
                  if (total == SCORE_MIN || part == SCORE_MIN) total = SCORE_MIN;
                  else if (part < 0 && total <= SCORE_MIN - part) total = SCORE_MIN;
                  else if (part > 0 && total > SCORE_MAX - part) total = SCORE_MAX;
                  else total = total + part;
               end
            end
            // clamp the sum onto the estimate range
            result.saturated = (total <= EST_MIN);
            if (total <= EST_MIN) total = EST_MIN;
            else if (total > EST_MAX) total = EST_MAX;
            result.estimate = total[EST_W-1:0];
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void add_row(input logic [OPCODE_W-1:0] opcode,
                                   input int span_start, input int span_end,
                                   input logic signed [ENTRY_W-1:0] score,
                                   input logic [COV_W-1:0] coverage, input logic span_enable,
                                   input logic has_literal,
                                   input logic [EST_W-1:0] estimate, input logic saturated);
      table_row_type row;
      row.request.opcode      = opcode;
      row.request.span_start  = span_start[POS_W-1:0];
      row.request.span_end    = span_end[POS_W-1:0];
      row.request.entry_score = score;
      row.request.coverage    = coverage;
      row.request.span_enable = span_enable;
      row.has_literal         = has_literal;
      row.literal.estimate    = estimate;
      row.literal.saturated   = saturated;
      directed_rows.push_back(row);
   endfunction

   function automatic span_request_type random_request();
      span_request_type r;
      r.opcode      = OPCODE_W'($urandom_range(0, 3));
      r.span_start  = POS_W'($urandom_range(0, NPOS-1));
      r.span_end    = POS_W'($urandom_range(0, NPOS-1));
      r.entry_score = $urandom();
      r.coverage    = $urandom();
      r.span_enable = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // Scores weighted toward the clamp and minus-infinity corners
   function automatic logic signed [ENTRY_W-1:0] random_score();
      case ($urandom_range(0, 7))
         0:       return MINUS_INF;
         1:       return 32'sh7FFF_FFFF;
         2:       return 32'sh8000_0001;
         3:       return {2'b01, 30'($urandom())};
         4:       return {2'b10, 30'($urandom())};
         5:       return $urandom();
         default: return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      endcase
   endfunction

   // Offer one request, hold it until taken, then predict its outcome
   task automatic send_request(input span_request_type r, input logic has_literal,
                               input estimate_type literal);
      estimate_type predicted;
      int           gap;
      if (bursts_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         gap = $urandom_range(1, 3);
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= r.opcode;
      req_bus.span_start  <= r.span_start;
      req_bus.span_end    <= r.span_end;
      req_bus.entry_score <= r.entry_score;
      req_bus.coverage    <= r.coverage;
      req_bus.span_enable <= r.span_enable;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (model_request(r, predicted))
         expected_estimates.push_back(has_literal ? literal : predicted);
      case (r.opcode)
         OP_WRITE: writes_sent++;
         OP_QUERY: queries_sent++;
         OP_CLEAR: clears_sent++;
         default:  ignored_sent++;
      endcase
      if (r.opcode != OP_UNDEFINED) requests_sent++;
   endtask

   // Response ready: random short stalls, plus one long hold-off on request
   initial begin : rsp_ready_gen
      int hold;
      forever begin
         if (hold_off_cycles != 0) begin
            rsp_bus.ready   <= 1'b0;
            hold            = hold_off_cycles;
            hold_off_cycles = 0;
         end else if (bursts_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            hold          = $urandom_range(1, 3);
         end else begin
            rsp_bus.ready <= 1'b1;
            hold          = 1;
         end
         repeat (hold) @(posedge clock);
      end
   end

   // Compare each taken estimate with the oldest prediction
   always @(posedge clock) begin : estimate_check
      estimate_type want;
      if (rsp_bus.valid && rsp_bus.ready) begin
         estimates_seen++;
         if (rsp_bus.saturated) saturated_seen++;
         if (expected_estimates.size() == 0) begin
            report_mismatch("estimate with no query pending", rsp_bus.estimate, 0);
         end else begin
            want = expected_estimates.pop_front();
            if (rsp_bus.estimate !== want.estimate)
               report_mismatch("estimate", rsp_bus.estimate, want.estimate);
            if (rsp_bus.saturated !== want.saturated)
               report_mismatch("saturated", rsp_bus.saturated, want.saturated);
         end
      end
   end

   initial begin : stimulus
      span_request_type r;
      logic [COV_W-1:0] cov;
      int               n_spans, lo, hi, k, p, kind;

      foreach (span_table[i, j]) span_table[i][j] = MINUS_INF;

      // Directed table: opcode, start, end, score, coverage, enable, literal?, estimate, sat
      add_row(OP_QUERY, 0, 0, 0, 32'h0000_0000, 0, 1, 32'h8000_0000, 1);
      add_row(OP_QUERY, 0, 0, 0, 32'hFFFF_FFFF, 0, 1, 32'h0000_0000, 0);
      add_row(OP_WRITE, 0, 31, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0);
      add_row(OP_QUERY, 0, 0, 0, 32'h0000_0000, 0, 1, 32'h7FFF_FFFF, 0);
      add_row(OP_WRITE, 2, 31, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0);
      add_row(OP_WRITE, 0, 0, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0);
      // two maximal scores clamp high without the flag
      add_row(OP_QUERY, 0, 0, 0, 32'h0000_0002, 0, 1, 32'h7FFF_FFFF, 0);
      add_row(OP_WRITE, 5, 5, 32'sh8000_0001, 0, 0, 0, 0, 0);
      add_row(OP_WRITE, 7, 31, -32'sd2, 0, 0, 0, 0, 0);
      // deep negative sum reaches minus infinity
      add_row(OP_QUERY, 0, 0, 0, 32'h0000_005F, 0, 1, 32'h8000_0000, 1);
      // extra covered span removes the trailing gap
      add_row(OP_QUERY, 6, 31, 0, 32'h0000_001F, 1, 1, 32'h8000_0001, 0);
      // empty extra span covers nothing
      add_row(OP_QUERY, 31, 0, 0, 32'hFFFF_FFFE, 1, 1, 32'h7FFF_FFFF, 0);
      add_row(OP_QUERY, 0, 31, 0, 32'h0000_0000, 1, 1, 32'h0000_0000, 0);
      // lower triangle write is never read back
      add_row(OP_WRITE, 31, 0, 32'sd5, 0, 0, 0, 0, 0);
      add_row(OP_QUERY, 0, 0, 0, 32'h7FFF_FFFF, 0, 1, 32'h8000_0000, 1);
      add_row(OP_WRITE, 31, 31, MINUS_INF, 0, 0, 0, 0, 0);
      add_row(OP_WRITE, 30, 31, 32'sh0001_0000, 0, 0, 0, 0, 0);
      add_row(OP_QUERY, 0, 0, 0, 32'h3FFF_FFFF, 0, 1, 32'h0001_0000, 0);
      add_row(OP_UNDEFINED, 3, 9, 32'sh1234_5678, 32'hF0F0_F0F0, 1, 0, 0, 0);
      add_row(OP_QUERY, 0, 0, 0, 32'hAAAA_AAAA, 0, 0, 0, 0);
      add_row(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_QUERY, 0, 0, 0, 32'h0000_0000, 0, 1, 32'h8000_0000, 1);
      add_row(OP_QUERY, 0, 0, 0, 32'hFFFF_FFFE, 0, 1, 32'h8000_0000, 1);
      add_row(OP_WRITE, 0, 0, 32'sd0, 0, 0, 0, 0, 0);
      add_row(OP_QUERY, 0, 0, 0, 32'hFFFF_FFFE, 0, 1, 32'h0000_0000, 0);

      // Hold reset, drive all inputs to known values
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.opcode      <= OP_WRITE;
      req_bus.span_start  <= '0;
      req_bus.span_end    <= '0;
      req_bus.entry_score <= '0;
      req_bus.coverage    <= '0;
      req_bus.span_enable <= 1'b0;
      repeat (4) @(posedge clock);
      reset     <= 1'b0;
      bursts_on = 1'b1;

      // Walk the directed table
      foreach (directed_rows[i])
         send_request(directed_rows[i].request, directed_rows[i].has_literal,
                      directed_rows[i].literal);

      // Random traffic; block the response side for a long stretch first
      hold_off_cycles = 250;
      while (requests_sent < REQUEST_TARGET) begin
         bursts_on = (requests_sent < REQUEST_TARGET - 150) && ($urandom_range(0, 3) != 0);
         kind      = $urandom_range(0, 99);
         r         = random_request();
         if ($urandom_range(0, 149) == 0) begin
            r.opcode = OP_CLEAR;
            send_request(r, 1'b0, '0);
         end else if (kind < 60) begin
            // write one to four spans, then query with their position bits cleared
            n_spans = $urandom_range(1, 4);
            cov     = ($urandom_range(0, 3) == 0) ? ($urandom() | $urandom()) : '1;
            for (k = 0; k < n_spans; k++) begin
               lo = $urandom_range(0, NPOS-1);
               if ($urandom_range(0, 5) == 0) hi = $urandom_range(lo, NPOS-1);
               else hi = lo + $urandom_range(0, 4);
               if (hi > NPOS-1) hi = NPOS-1;
               r             = random_request();
               r.opcode      = OP_WRITE;
               r.span_start  = lo[POS_W-1:0];
               r.span_end    = hi[POS_W-1:0];
               r.entry_score = random_score();
               send_request(r, 1'b0, '0);
               for (p = lo; p <= hi; p++) cov[p] = 1'b0;
            end
            r             = random_request();
            r.opcode      = OP_QUERY;
            r.coverage    = cov;
            r.span_enable = ($urandom_range(0, 3) == 0);
            send_request(r, 1'b0, '0);
         end else if (kind < 80) begin
            r.opcode = OP_QUERY;
            case ($urandom_range(0, 2))
               0:       r.coverage = $urandom();
               1:       r.coverage = $urandom() | $urandom();
               default: r.coverage = $urandom() | $urandom() | $urandom();
            endcase
            send_request(r, 1'b0, '0);
         end else if (kind < 95) begin
            r.opcode      = OP_WRITE;
            r.entry_score = random_score();
            send_request(r, 1'b0, '0);
         end else begin
            r.opcode = OP_UNDEFINED;
            send_request(r, 1'b0, '0);
         end
      end
      req_bus.valid <= 1'b0;

      // Drain outstanding estimates, then allow a query's latency more
      while (expected_estimates.size() != 0) @(posedge clock);
      repeat (2 * NPOS) @(posedge clock);

      $display("summary: %0d requests (%0d writes, %0d queries, %0d clears), %0d ignored",
               requests_sent, writes_sent, queries_sent, clears_sent, ignored_sent);
      $display("summary: %0d estimates checked, %0d at minus infinity, %0d mismatches",
               estimates_seen, saturated_seen, error_count);
      if (error_count == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/gss_pkg.sv
rtl/gss_if.sv
rtl/gss_ctrl.sv
rtl/gss_datapath.sv
rtl/gap_span_score_sum.sv
rtl/gss_checker.sv
test/testbench.sv
